>>> hw/rtl/ppp_pkg.sv
// ----------------------------------------------------------------------------
// ppp_pkg: shared constants and helpers
// Widths, fixed-point constants, register codes and the bit-length helper
// used by the preference probability datapath.
// ----------------------------------------------------------------------------
package ppp_pkg;

    // Field widths
    localparam int VALUE_BITS  = 16;
    localparam int PROB_BITS   = 16;
    localparam int DISC_BITS   = VALUE_BITS - 1;
    localparam int ARG_BITS    = VALUE_BITS + 3;   // 2(x-d)-t and 3(x-d)
    localparam int Z_BITS      = 29;               // clamped Q.24 argument, +-2^27
    localparam int EXP_BITS    = 44;               // exp() in Q.32, below 2^44
    localparam int NUM_BITS    = EXP_BITS + 1;
    localparam int DEN_BITS    = EXP_BITS + 3;
    localparam int SIDE_P_BITS = 32;               // side probability, Q0.32
    localparam int NORM_BITS   = 31;               // operands kept below 2^31
    localparam int LEN_BITS    = 7;

    // Pipeline depths
    localparam int HORNER_STEPS    = 9;
    localparam int SIDE_DIV_STEPS  = SIDE_P_BITS;
    localparam int FINAL_DIV_STEPS = PROB_BITS;

    // Fixed-point constants
    localparam logic [28:0] LOG2E_Q28 = 29'd387270501;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [31:0] ONE_Q30   = 32'h4000_0000;
    localparam logic signed [Z_BITS-1:0] ARG_LIMIT = 29'sd134217728;
    localparam logic [4:0]  EXP_POINT = 5'd14;     // Q.30 mantissa to Q.32 at k=16

    // floor(2^32 / n) for the Horner divisors 9 down to 1
    localparam logic [32:0] RECIP_TAB [HORNER_STEPS] = '{
        33'd477218588, 33'd536870912, 33'd613566756,
        33'd715827882, 33'd858993459, 33'd1073741824,
        33'd1431655765, 33'd2147483648, 33'd4294967296
    };

    // Output codes
    localparam logic [PROB_BITS-1:0] PROB_HALF = PROB_BITS'(1) << (PROB_BITS - 1);
    localparam logic [PROB_BITS-1:0] PROB_MAX  = '1;

    // Configuration registers
    localparam int ADDR_BITS = 5;
    localparam logic [2:0] REG_DISC_S   = 3'd0;
    localparam logic [2:0] REG_LOC_S    = 3'd1;
    localparam logic [2:0] REG_THRESH_S = 3'd2;
    localparam logic [2:0] REG_DISC_T   = 3'd3;
    localparam logic [2:0] REG_LOC_T    = 3'd4;
    localparam logic [2:0] REG_THRESH_T = 3'd5;
    localparam logic [DISC_BITS-1:0] DISC_RESET = DISC_BITS'(4096);

    // Position of the highest set bit plus one, zero for a zero word
    function automatic logic [LEN_BITS-1:0] bit_len64(input logic [63:0] val);
        logic [LEN_BITS-1:0] len;
        len = '0;
        for (int i = 0; i < 64; i++) begin
            if (val[i]) begin
                len = LEN_BITS'(i + 1);
            end
        end
        return len;
    endfunction

endpackage

>>> hw/rtl/ppp_exp.sv
// ----------------------------------------------------------------------------
// ppp_exp: pipelined fixed-point exponential
// Forms z = a*w clamped to +-8, splits z*log2(e) into integer and fraction,
// evaluates 2^frac by a nine-step Horner series, three stages per step, and
// shifts the result into Q.32. One argument per cycle while en is high.
// ----------------------------------------------------------------------------
module ppp_exp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic [ppp_pkg::DISC_BITS-1:0]         disc,
    input  logic signed [ppp_pkg::ARG_BITS-1:0]   arg,
    output logic                                  out_valid,
    output logic [ppp_pkg::EXP_BITS-1:0]          exp_val
);
    import ppp_pkg::*;

    // Stage 1: argument product and clamp
    logic signed [DISC_BITS+ARG_BITS:0] arg_prod;
    logic signed [Z_BITS-1:0]           z_next;
    logic signed [Z_BITS-1:0]           z_reg;
    logic                               v1_reg;

    assign arg_prod = $signed({1'b0, disc}) * arg;

    always_comb
    begin
        priority if (arg_prod > ARG_LIMIT)
        begin
            z_next = ARG_LIMIT;
        end
        else if (arg_prod < -ARG_LIMIT)
        begin
            z_next = -ARG_LIMIT;
        end
        else
        begin
            z_next = arg_prod[Z_BITS-1:0];
        end
    end

    // Stage 2: scale by log2(e), split integer and fraction
    logic signed [59:0] y_prod;
    logic [59:0]        y_pos;
    logic [4:0]         k2_reg;
    logic [23:0]        f2_reg;
    logic               v2_reg;

    assign y_prod = z_reg * $signed({1'b0, LOG2E_Q28});
    assign y_pos  = $unsigned(y_prod) + (60'd1 << 56);

    // Stage 3: fraction times ln2
    logic [53:0] r_prod;

    assign r_prod = f2_reg * LN2_Q30;

    // Horner chain: index i is the input of step i
    logic [31:0] acc_c [HORNER_STEPS+1];
    logic [29:0] r_c   [HORNER_STEPS+1];
    logic [4:0]  k_c   [HORNER_STEPS+1];
    logic        vld_c [HORNER_STEPS+1];

    logic [31:0] v_a   [HORNER_STEPS];
    logic [29:0] r_a   [HORNER_STEPS];
    logic [4:0]  k_a   [HORNER_STEPS];
    logic        vld_a [HORNER_STEPS];
    logic [31:0] v_b   [HORNER_STEPS];
    logic [31:0] q_b   [HORNER_STEPS];
    logic [29:0] r_b   [HORNER_STEPS];
    logic [4:0]  k_b   [HORNER_STEPS];
    logic        vld_b [HORNER_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            vld_c[0] <= 1'b0;
        end
        else if (en)
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            vld_c[0] <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg    <= z_next;
            k2_reg   <= y_pos[56:52];
            f2_reg   <= y_pos[51:28];
            acc_c[0] <= ONE_Q30;
            r_c[0]   <= r_prod[53:24];
            k_c[0]   <= k2_reg;
        end
    end

    for (genvar i = 0; i < HORNER_STEPS; i++)
    begin : g_step
        localparam int DIVISOR = HORNER_STEPS - i;

        logic [61:0] prod_a;
        logic [64:0] prod_b;
        logic [35:0] back_c;
        logic [31:0] rem_c;
        logic [31:0] quot_c;

        // acc*r, then divide by a constant through its reciprocal
        assign prod_a = acc_c[i] * r_c[i];
        assign prod_b = v_a[i] * RECIP_TAB[i];
        assign back_c = q_b[i] * 4'(DIVISOR);
        assign rem_c  = v_b[i] - back_c[31:0];
        assign quot_c = (rem_c >= 32'(DIVISOR)) ? q_b[i] + 32'd1 : q_b[i];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_a[i]   <= 1'b0;
                vld_b[i]   <= 1'b0;
                vld_c[i+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_a[i]   <= vld_c[i];
                vld_b[i]   <= vld_a[i];
                vld_c[i+1] <= vld_b[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_a[i]     <= prod_a[61:30];
                r_a[i]     <= r_c[i];
                k_a[i]     <= k_c[i];
                v_b[i]     <= v_a[i];
                q_b[i]     <= prod_b[63:32];
                r_b[i]     <= r_a[i];
                k_b[i]     <= k_a[i];
                acc_c[i+1] <= ONE_Q30 + quot_c;
                r_c[i+1]   <= r_b[i];
                k_c[i+1]   <= k_b[i];
            end
        end
    end

    // Final stage: scale 2^frac by 2^(k-14)
    logic [EXP_BITS-1:0] wide_acc;
    logic [4:0]          k_fin;
    logic [EXP_BITS-1:0] exp_next;
    logic [EXP_BITS-1:0] exp_reg;
    logic                out_valid_reg;

    assign wide_acc = EXP_BITS'(acc_c[HORNER_STEPS]);
    assign k_fin    = k_c[HORNER_STEPS];
    assign exp_next = (k_fin >= EXP_POINT) ? (wide_acc << (k_fin - EXP_POINT))
                                           : (wide_acc >> (EXP_POINT - k_fin));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld_c[HORNER_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            exp_reg <= exp_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign exp_val   = exp_reg;

endmodule

>>> hw/rtl/ppp_side.sv
// ----------------------------------------------------------------------------
// ppp_side: agreement probability of one statement
// Builds the three exponent arguments, runs three exponential pipelines,
// normalizes numerator and denominator below 2^31 and divides with a
// 32-stage restoring divider. Result Q0.32.
// ----------------------------------------------------------------------------
module ppp_side (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic signed [ppp_pkg::VALUE_BITS-1:0]  trait,
    input  logic [ppp_pkg::DISC_BITS-1:0]          disc,
    input  logic signed [ppp_pkg::VALUE_BITS-1:0]  loc,
    input  logic signed [ppp_pkg::VALUE_BITS-1:0]  thresh,
    output logic                                   out_valid,
    output logic [ppp_pkg::SIDE_P_BITS-1:0]        prob
);
    import ppp_pkg::*;

    // Stage 1: exponent arguments in Q.12
    logic signed [VALUE_BITS:0]   u_diff;
    logic signed [ARG_BITS-1:0]   u_ext;
    logic signed [ARG_BITS-1:0]   t_ext;
    logic signed [ARG_BITS-1:0]   w_reg [3];
    logic                         w_vld_reg;

    assign u_diff = trait - loc;
    assign u_ext  = ARG_BITS'(u_diff);
    assign t_ext  = ARG_BITS'(thresh);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            w_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg[0] <= u_ext - t_ext;
            w_reg[1] <= (u_ext <<< 1) - t_ext;
            w_reg[2] <= (u_ext <<< 1) + u_ext;
        end
    end

    // Three exponentials
    logic [EXP_BITS-1:0] e_val [3];
    logic                e_vld [3];

    for (genvar j = 0; j < 3; j++)
    begin : g_exp
        ppp_exp u_exp (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (w_vld_reg),
            .disc      (disc),
            .arg       (w_reg[j]),
            .out_valid (e_vld[j]),
            .exp_val   (e_val[j])
        );
    end

    // Numerator and denominator
    logic [NUM_BITS-1:0] num_next;
    logic [NUM_BITS-1:0] num1_reg;
    logic [DEN_BITS-1:0] den1_reg;
    logic                n1_vld_reg;

    assign num_next = NUM_BITS'(e_val[0]) + NUM_BITS'(e_val[1]);

    // Normalization amount, then the shift
    logic [LEN_BITS-1:0] den_len;
    logic [4:0]          sh_next;
    logic [NUM_BITS-1:0] num2_reg;
    logic [DEN_BITS-1:0] den2_reg;
    logic [4:0]          sh2_reg;
    logic                n2_vld_reg;

    assign den_len = bit_len64(64'(den1_reg));
    assign sh_next = (den_len > LEN_BITS'(NORM_BITS)) ? 5'(den_len - LEN_BITS'(NORM_BITS))
                                                     : 5'd0;

    // Divider chain: index 0 is the normalized pair
    logic [NORM_BITS-1:0]   rem_d [SIDE_DIV_STEPS+1];
    logic [NORM_BITS-1:0]   dv_d  [SIDE_DIV_STEPS+1];
    logic [SIDE_P_BITS-1:0] quo_d [SIDE_DIV_STEPS+1];
    logic                   vld_d [SIDE_DIV_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n1_vld_reg <= 1'b0;
            n2_vld_reg <= 1'b0;
            vld_d[0]   <= 1'b0;
        end
        else if (en)
        begin
            n1_vld_reg <= e_vld[0] & e_vld[1] & e_vld[2];
            n2_vld_reg <= n1_vld_reg;
            vld_d[0]   <= n2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num1_reg <= num_next;
            den1_reg <= DEN_BITS'(num_next) + DEN_BITS'(e_val[2]) + (DEN_BITS'(1) << 32);
            num2_reg <= num1_reg;
            den2_reg <= den1_reg;
            sh2_reg  <= sh_next;
            rem_d[0] <= NORM_BITS'(num2_reg >> sh2_reg);
            dv_d[0]  <= NORM_BITS'(den2_reg >> sh2_reg);
            quo_d[0] <= '0;
        end
    end

    // One quotient bit per stage
    for (genvar s = 0; s < SIDE_DIV_STEPS; s++)
    begin : g_div
        logic [NORM_BITS:0] trial;
        logic [NORM_BITS:0] diff;
        logic               take;

        assign trial = {rem_d[s], 1'b0};
        assign diff  = trial - {1'b0, dv_d[s]};
        assign take  = (trial >= {1'b0, dv_d[s]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_d[s+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_d[s+1] <= vld_d[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_d[s+1] <= take ? diff[NORM_BITS-1:0] : trial[NORM_BITS-1:0];
                dv_d[s+1]  <= dv_d[s];
                quo_d[s+1] <= {quo_d[s][SIDE_P_BITS-2:0], take};
            end
        end
    end

    assign out_valid = vld_d[SIDE_DIV_STEPS];
    assign prob      = quo_d[SIDE_DIV_STEPS];

`ifndef ASSERT_OFF
    // The three exponential pipelines stay in lockstep
    a_exp_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (e_vld[0] == e_vld[1]) && (e_vld[1] == e_vld[2]))
        else $error("exponential pipelines out of step");

    // Denominator is at least one, so after normalization its top bit is set
    a_den_norm: assert property (@(posedge clk) disable iff (!rst_n)
        vld_d[0] |-> dv_d[0][NORM_BITS-1])
        else $error("divisor not normalized");

    // Numerator stays below denominator, quotient fits 32 bits
    a_num_below: assert property (@(posedge clk) disable iff (!rst_n)
        vld_d[0] |-> (rem_d[0] < dv_d[0]))
        else $error("numerator not below denominator");
`endif

endmodule

>>> hw/rtl/pairwise_preference_probability_core.sv
// ----------------------------------------------------------------------------
// pairwise_preference_probability_core: P(statement s preferred to t)
// Two trait values in, one Q0.16 preference probability out, using the
// statement parameters held in the configuration registers.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration goes in over the APB port (six registers at 4-byte steps)
//   while no transfer is in flight. Trait pairs come in on the trait channel
//   (trait_valid / trait_stall) and results leave on the pref channel
//   (pref_valid / pref_stall).
//   The pipeline takes one pair every cycle while it is not stalled. Its
//   depth is set by the nine-step Horner series of the exponentials
//   (27 stages), the 32-stage side divider and the 16-stage final divider.
//   When the receiver stalls a valid result, the whole pipeline holds in
//   place and trait_stall rises in the same cycle; nothing is dropped.
//   Reset clears every valid bit and loads the register defaults
//   (discriminations 1.0, locations and thresholds 0). No clearing pass.
// ----------------------------------------------------------------------------
module pairwise_preference_probability_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [ppp_pkg::ADDR_BITS-1:0]          paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready,
    // trait channel
    input  logic                                   trait_valid,
    output logic                                   trait_stall,
    input  logic signed [ppp_pkg::VALUE_BITS-1:0]  trait_s,
    input  logic signed [ppp_pkg::VALUE_BITS-1:0]  trait_t,
    // result channel
    output logic                                   pref_valid,
    input  logic                                   pref_stall,
    output logic [ppp_pkg::PROB_BITS-1:0]          pref_prob
);
    import ppp_pkg::*;

    // Configuration registers
    logic [DISC_BITS-1:0]  disc_s_reg;
    logic [VALUE_BITS-1:0] loc_s_reg;
    logic [VALUE_BITS-1:0] thresh_s_reg;
    logic [DISC_BITS-1:0]  disc_t_reg;
    logic [VALUE_BITS-1:0] loc_t_reg;
    logic [VALUE_BITS-1:0] thresh_t_reg;
    logic [2:0]            reg_idx;
    logic                  cfg_wr;

    assign reg_idx = paddr[ADDR_BITS-1:2];
    assign cfg_wr  = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disc_s_reg   <= DISC_RESET;
            loc_s_reg    <= '0;
            thresh_s_reg <= '0;
            disc_t_reg   <= DISC_RESET;
            loc_t_reg    <= '0;
            thresh_t_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_DISC_S:   disc_s_reg   <= pwdata[DISC_BITS-1:0];
                REG_LOC_S:    loc_s_reg    <= pwdata[VALUE_BITS-1:0];
                REG_THRESH_S: thresh_s_reg <= pwdata[VALUE_BITS-1:0];
                REG_DISC_T:   disc_t_reg   <= pwdata[DISC_BITS-1:0];
                REG_LOC_T:    loc_t_reg    <= pwdata[VALUE_BITS-1:0];
                REG_THRESH_T: thresh_t_reg <= pwdata[VALUE_BITS-1:0];
                default:      ;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (reg_idx)
            REG_DISC_S:   prdata = 32'(disc_s_reg);
            REG_LOC_S:    prdata = 32'(loc_s_reg);
            REG_THRESH_S: prdata = 32'(thresh_s_reg);
            REG_DISC_T:   prdata = 32'(disc_t_reg);
            REG_LOC_T:    prdata = 32'(loc_t_reg);
            REG_THRESH_T: prdata = 32'(thresh_t_reg);
            default:      prdata = '0;
        endcase
    end

    // Global advance: hold everything while a result waits under stall
    logic en;
    logic pref_valid_reg;

    assign en          = !(pref_valid_reg && pref_stall);
    assign trait_stall = !en;

    // Both sides
    logic                   ps_valid;
    logic                   pt_valid;
    logic [SIDE_P_BITS-1:0] pa;
    logic [SIDE_P_BITS-1:0] pt;

    ppp_side u_side_s (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (trait_valid),
        .trait     (trait_s),
        .disc      (disc_s_reg),
        .loc       ($signed(loc_s_reg)),
        .thresh    ($signed(thresh_s_reg)),
        .out_valid (ps_valid),
        .prob      (pa)
    );

    ppp_side u_side_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (trait_valid),
        .trait     (trait_t),
        .disc      (disc_t_reg),
        .loc       ($signed(loc_t_reg)),
        .thresh    ($signed(thresh_t_reg)),
        .out_valid (pt_valid),
        .prob      (pt)
    );

    // C1: P = A*B, Q = (1-A)*(1-B) with B = 1 - p_t
    logic [SIDE_P_BITS:0]   pb;
    logic [SIDE_P_BITS:0]   qa;
    logic [64:0]            p_prod;
    logic [64:0]            q_prod;
    logic [63:0]            p1_reg;
    logic [63:0]            q1_reg;
    logic                   c1_vld_reg;

    assign pb     = (33'd1 << 32) - 33'(pt);
    assign qa     = (33'd1 << 32) - 33'(pa);
    assign p_prod = pa * pb;
    assign q_prod = qa * pt;

    // C2: halve and sum
    logic [62:0] p2_reg;
    logic [62:0] q2_reg;
    logic [63:0] sum2_reg;
    logic        c2_vld_reg;

    // C3: shift amount, one short of the bit-length bound
    logic [LEN_BITS-1:0] sum_len;
    logic [5:0]          s0;
    logic [62:0]         p3_reg;
    logic [62:0]         q3_reg;
    logic [5:0]          sm3_reg;
    logic                extra3_reg;
    logic                c3_vld_reg;

    assign sum_len = bit_len64(sum2_reg);
    assign s0      = (sum_len > LEN_BITS'(NORM_BITS)) ? 6'(sum_len - LEN_BITS'(NORM_BITS))
                                                     : 6'd0;

    // C4: shifted pair
    logic [31:0] p4_reg;
    logic [31:0] q4_reg;
    logic        extra4_reg;
    logic        c4_vld_reg;

    // C5: one more halving when the floored sum is still too wide
    logic [32:0]          sum4;
    logic [31:0]          p4h;
    logic [31:0]          q4h;
    logic [32:0]          sum4h;
    logic [NORM_BITS-1:0] p5_next;
    logic [NORM_BITS-1:0] sum5_next;
    logic [NORM_BITS-1:0] p5_reg;
    logic [NORM_BITS-1:0] sum5_reg;
    logic                 c5_vld_reg;

    assign sum4  = 33'(p4_reg) + 33'(q4_reg);
    assign p4h   = p4_reg >> 1;
    assign q4h   = q4_reg >> 1;
    assign sum4h = 33'(p4h) + 33'(q4h);

    always_comb
    begin
        if (extra4_reg && (sum4 >= (33'd1 << NORM_BITS)))
        begin
            p5_next   = p4h[NORM_BITS-1:0];
            sum5_next = sum4h[NORM_BITS-1:0];
        end
        else
        begin
            p5_next   = p4_reg[NORM_BITS-1:0];
            sum5_next = sum4[NORM_BITS-1:0];
        end
    end

    // C6: integer quotient bit, divider entry
    logic [NORM_BITS-1:0]  frem [FINAL_DIV_STEPS+1];
    logic [NORM_BITS-1:0]  fdv  [FINAL_DIV_STEPS+1];
    logic [PROB_BITS:0]    fquo [FINAL_DIV_STEPS+1];
    logic                  fzero[FINAL_DIV_STEPS+1];
    logic                  fvld [FINAL_DIV_STEPS+1];
    logic                  int_take;

    assign int_take = (p5_reg >= sum5_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_vld_reg <= 1'b0;
            c2_vld_reg <= 1'b0;
            c3_vld_reg <= 1'b0;
            c4_vld_reg <= 1'b0;
            c5_vld_reg <= 1'b0;
            fvld[0]    <= 1'b0;
        end
        else if (en)
        begin
            c1_vld_reg <= ps_valid & pt_valid;
            c2_vld_reg <= c1_vld_reg;
            c3_vld_reg <= c2_vld_reg;
            c4_vld_reg <= c3_vld_reg;
            c5_vld_reg <= c4_vld_reg;
            fvld[0]    <= c5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg     <= p_prod[63:0];
            q1_reg     <= q_prod[63:0];
            p2_reg     <= p1_reg[63:1];
            q2_reg     <= q1_reg[63:1];
            sum2_reg   <= 64'(p1_reg[63:1]) + 64'(q1_reg[63:1]);
            p3_reg     <= p2_reg;
            q3_reg     <= q2_reg;
            sm3_reg    <= (s0 != 6'd0) ? s0 - 6'd1 : 6'd0;
            extra3_reg <= (s0 != 6'd0);
            p4_reg     <= 32'(p3_reg >> sm3_reg);
            q4_reg     <= 32'(q3_reg >> sm3_reg);
            extra4_reg <= extra3_reg;
            p5_reg     <= p5_next;
            sum5_reg   <= sum5_next;
            frem[0]    <= int_take ? p5_reg - sum5_reg : p5_reg;
            fdv[0]     <= sum5_reg;
            fquo[0]    <= (PROB_BITS+1)'(int_take);
            fzero[0]   <= (sum5_reg == '0);
        end
    end

    // Fraction bits, one per stage
    for (genvar s = 0; s < FINAL_DIV_STEPS; s++)
    begin : g_fdiv
        logic [NORM_BITS:0] trial;
        logic [NORM_BITS:0] diff;
        logic               take;

        assign trial = {frem[s], 1'b0};
        assign diff  = trial - {1'b0, fdv[s]};
        assign take  = (trial >= {1'b0, fdv[s]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                fvld[s+1] <= 1'b0;
            end
            else if (en)
            begin
                fvld[s+1] <= fvld[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                frem[s+1]  <= take ? diff[NORM_BITS-1:0] : trial[NORM_BITS-1:0];
                fdv[s+1]   <= fdv[s];
                fquo[s+1]  <= {fquo[s][PROB_BITS-1:0], take};
                fzero[s+1] <= fzero[s];
            end
        end
    end

    // Output register: undefined ratio gives one half, 1.0 saturates
    logic [PROB_BITS:0]   quo_fin;
    logic [PROB_BITS-1:0] prob_next;
    logic [PROB_BITS-1:0] prob_reg;

    assign quo_fin = fquo[FINAL_DIV_STEPS];

    always_comb
    begin
        priority if (fzero[FINAL_DIV_STEPS])
        begin
            prob_next = PROB_HALF;
        end
        else if (quo_fin[PROB_BITS])
        begin
            prob_next = PROB_MAX;
        end
        else
        begin
            prob_next = quo_fin[PROB_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pref_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pref_valid_reg <= fvld[FINAL_DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && fvld[FINAL_DIV_STEPS])
        begin
            prob_reg <= prob_next;
        end
    end

    assign pref_valid = pref_valid_reg;
    assign pref_prob  = prob_reg;

`ifndef ASSERT_OFF
    // Both side pipelines deliver the same item in the same cycle
    a_sides_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        ps_valid == pt_valid)
        else $error("side pipelines out of step");

    // Divider entry: remainder below a nonzero divisor
    a_fdiv_entry: assert property (@(posedge clk) disable iff (!rst_n)
        fvld[0] |-> (fzero[0] || (frem[0] < fdv[0])))
        else $error("final divider entry out of range");

    // Quotient never exceeds 1.0
    a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fvld[FINAL_DIV_STEPS] |-> (!quo_fin[PROB_BITS] || (quo_fin[PROB_BITS-1:0] == '0)))
        else $error("final quotient above one");
`endif

endmodule
